// File: hw/rtl/sst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the scoped symbol table.
// Used by sst_cell, sst_ctrl and scoped_symbol_table_top; depends on nothing.
package sst_pkg;

   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_KEY_WIDTH   = 32;
   localparam int DEF_MAX_LEVEL   = 255;

   localparam int REQ_TYPE_W = 2;
   localparam int KEY_FIELD_W = 32;
   localparam int VALUE_W = 64;
   localparam int STATUS_W = 3;

   localparam logic [REQ_TYPE_W-1:0] REQ_BIND = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_GET  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_LEVEL   = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POP
   } sst_state_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic load;       // capture own compare result into the probe
      logic bind_mode;  // compare only entries at or above the current level
      logic step;       // probe moves one cell towards the head
      logic shift_in;   // every entry moves one cell away from the head
      logic shift_out;  // every entry moves one cell towards the head
   } sst_cell_cmd_type;

endpackage

// File: hw/rtl/scoped_symbol_table_top.sv
`timescale 1ns / 1ps
// Scoped symbol table: a chain of TABLE_DEPTH cells, newest binding at the head.
// Bind and get: busy during the scan, as the search probe moves one cell a cycle from the
// oldest entry to the head. Pop: busy while it drops the closing scope's entries. Push and
// pop at level zero never raise busy. Each response is strobed for one cycle, right after
// the last busy cycle (after the request cycle for push and for pop at level zero).
// Synchronous reset empties the table and sets the level to zero; no receiver stall.
module scoped_symbol_table_top #(
   parameter int TABLE_DEPTH = sst_pkg::DEF_TABLE_DEPTH,
   parameter int KEY_WIDTH   = sst_pkg::DEF_KEY_WIDTH,
   parameter int MAX_LEVEL   = sst_pkg::DEF_MAX_LEVEL
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [sst_pkg::REQ_TYPE_W-1:0]  req_type,
   input  logic [sst_pkg::KEY_FIELD_W-1:0] req_key,
   input  logic [sst_pkg::VALUE_W-1:0]     req_bind_value,
   output logic                            rsp_strobe,
   output logic [sst_pkg::STATUS_W-1:0]    rsp_status,
   output logic [sst_pkg::VALUE_W-1:0]     rsp_found_value
);

   localparam int KeyW   = (KEY_WIDTH < sst_pkg::KEY_FIELD_W) ? KEY_WIDTH
                                                               : sst_pkg::KEY_FIELD_W;
   localparam int LevelW = $clog2(MAX_LEVEL + 1);
   localparam int CountW = $clog2(TABLE_DEPTH + 1);

   sst_pkg::sst_cell_cmd_type    cmd;
   logic [CountW-1:0]            count;
   logic [LevelW-1:0]            cur_level;
   logic [KeyW-1:0]              match_key;
   logic [KeyW-1:0]              new_key;
   logic [sst_pkg::VALUE_W-1:0]  new_value;

   logic [KeyW-1:0]              cell_key   [TABLE_DEPTH];
   logic [sst_pkg::VALUE_W-1:0]  cell_value [TABLE_DEPTH];
   logic [LevelW-1:0]            cell_level [TABLE_DEPTH];
   logic                         cell_found [TABLE_DEPTH];
   logic [sst_pkg::VALUE_W-1:0]  cell_pval  [TABLE_DEPTH];

   sst_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_LEVEL   (MAX_LEVEL),
      .KEY_W       (KeyW),
      .LEVEL_W     (LevelW),
      .COUNT_W     (CountW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_bind_value  (req_bind_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value),
      .head_found      (cell_found[0]),
      .head_pval       (cell_pval[0]),
      .head_level      (cell_level[0]),
      .cmd             (cmd),
      .count           (count),
      .cur_level       (cur_level),
      .match_key       (match_key),
      .new_key         (new_key),
      .new_value       (new_value)
   );

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [KeyW-1:0]             nk, ok;
      logic [sst_pkg::VALUE_W-1:0] nv, ov, opv;
      logic [LevelW-1:0]           nl, ol;
      logic                        ofound;

      // head takes the new binding; tail has no older match and keeps its own entry
      if (i == 0) begin : g_head
         assign nk = new_key;
         assign nv = new_value;
         assign nl = cur_level;
      end else begin : g_body
         assign nk = cell_key[i-1];
         assign nv = cell_value[i-1];
         assign nl = cell_level[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign ok     = cell_key[i];
         assign ov     = cell_value[i];
         assign ol     = cell_level[i];
         assign ofound = 1'b0;
         assign opv    = '0;
      end else begin : g_inner
         assign ok     = cell_key[i+1];
         assign ov     = cell_value[i+1];
         assign ol     = cell_level[i+1];
         assign ofound = cell_found[i+1];
         assign opv    = cell_pval[i+1];
      end

      sst_cell #(
         .INDEX   (i),
         .KEY_W   (KeyW),
         .LEVEL_W (LevelW),
         .COUNT_W (CountW)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count),
         .match_key   (match_key),
         .cur_level   (cur_level),
         .newer_key   (nk),
         .newer_value (nv),
         .newer_level (nl),
         .older_key   (ok),
         .older_value (ov),
         .older_level (ol),
         .older_found (ofound),
         .older_pval  (opv),
         .key_o       (cell_key[i]),
         .value_o     (cell_value[i]),
         .level_o     (cell_level[i]),
         .found_o     (cell_found[i]),
         .pval_o      (cell_pval[i])
      );
   end

endmodule

// File: hw/rtl/sst_cell.sv
`timescale 1ns / 1ps
// One cell of the binding chain: holds one entry and one stage of the search probe.
// Depends on sst_pkg.
module sst_cell #(
   parameter int INDEX   = 0,
   parameter int KEY_W   = 32,
   parameter int LEVEL_W = 8,
   parameter int COUNT_W = 9
) (
   input  logic                        clock,
   input  sst_pkg::sst_cell_cmd_type   cmd,
   input  logic [COUNT_W-1:0]          count,
   input  logic [KEY_W-1:0]            match_key,
   input  logic [LEVEL_W-1:0]          cur_level,
   input  logic [KEY_W-1:0]            newer_key,
   input  logic [sst_pkg::VALUE_W-1:0] newer_value,
   input  logic [LEVEL_W-1:0]          newer_level,
   input  logic [KEY_W-1:0]            older_key,
   input  logic [sst_pkg::VALUE_W-1:0] older_value,
   input  logic [LEVEL_W-1:0]          older_level,
   input  logic                        older_found,
   input  logic [sst_pkg::VALUE_W-1:0] older_pval,
   output logic [KEY_W-1:0]            key_o,
   output logic [sst_pkg::VALUE_W-1:0] value_o,
   output logic [LEVEL_W-1:0]          level_o,
   output logic                        found_o,
   output logic [sst_pkg::VALUE_W-1:0] pval_o
);

   logic [KEY_W-1:0]            key_ff, key_in;
   logic [sst_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [LEVEL_W-1:0]          level_ff, level_in;
   logic                        found_ff, found_in;
   logic [sst_pkg::VALUE_W-1:0] pval_ff, pval_in;
   logic                        entry_valid;
   logic                        hit;

   assign entry_valid = count > COUNT_W'(INDEX);
   assign hit = entry_valid && (key_ff == match_key) &&
                (!cmd.bind_mode || (level_ff >= cur_level));

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      level_in = level_ff;
      if (cmd.shift_in) begin
         key_in   = newer_key;
         value_in = newer_value;
         level_in = newer_level;
      end else if (cmd.shift_out) begin
         key_in   = older_key;
         value_in = older_value;
         level_in = older_level;
      end
   end

   // Load captures own hit; on step, keep a found result or take the older cell's.
   always_comb begin
      found_in = found_ff;
      pval_in  = pval_ff;
      if (cmd.load) begin
         found_in = hit;
         pval_in  = value_ff;
      end else if (cmd.step && !found_ff) begin
         found_in = older_found;
         pval_in  = older_pval;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      level_ff <= level_in;
      found_ff <= found_in;
      pval_ff  <= pval_in;
   end

   assign key_o   = key_ff;
   assign value_o = value_ff;
   assign level_o = level_ff;
   assign found_o = found_ff;
   assign pval_o  = pval_ff;

endmodule

// File: hw/rtl/sst_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer for the scoped symbol table: entry count, nesting level,
// scan and pop sequencing, and the registered response. Depends on sst_pkg.
module sst_ctrl #(
   parameter int TABLE_DEPTH = sst_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_LEVEL   = sst_pkg::DEF_MAX_LEVEL,
   parameter int KEY_W       = sst_pkg::DEF_KEY_WIDTH,
   parameter int LEVEL_W     = 8,
   parameter int COUNT_W     = 9
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [sst_pkg::REQ_TYPE_W-1:0]     req_type,
   input  logic [sst_pkg::KEY_FIELD_W-1:0]    req_key,
   input  logic [sst_pkg::VALUE_W-1:0]        req_bind_value,
   output logic                               rsp_strobe,
   output logic [sst_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sst_pkg::VALUE_W-1:0]        rsp_found_value,
   input  logic                               head_found,
   input  logic [sst_pkg::VALUE_W-1:0]        head_pval,
   input  logic [LEVEL_W-1:0]                 head_level,
   output sst_pkg::sst_cell_cmd_type          cmd,
   output logic [COUNT_W-1:0]                 count,
   output logic [LEVEL_W-1:0]                 cur_level,
   output logic [KEY_W-1:0]                   match_key,
   output logic [KEY_W-1:0]                   new_key,
   output logic [sst_pkg::VALUE_W-1:0]        new_value
);

   sst_pkg::sst_state_type        state_ff, state_in;
   logic [COUNT_W-1:0]            count_ff, count_in;
   logic [LEVEL_W-1:0]            level_ff, level_in;
   logic [COUNT_W-1:0]            remain_ff, remain_in;
   logic                          bind_ff, bind_in;
   logic [KEY_W-1:0]              key_ff, key_in;
   logic [sst_pkg::VALUE_W-1:0]   value_ff, value_in;
   logic                          strobe_ff, strobe_in;
   logic [sst_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [sst_pkg::VALUE_W-1:0]   fval_ff, fval_in;

   assign match_key = req_key[KEY_W-1:0];

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      level_in  = level_ff;
      remain_in = remain_ff;
      bind_in   = bind_ff;
      key_in    = key_ff;
      value_in  = value_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      fval_in   = fval_ff;
      cmd       = '0;
      case (state_ff)
         sst_pkg::ST_IDLE: begin
            if (start) begin
               case (req_type)
                  sst_pkg::REQ_BIND, sst_pkg::REQ_GET: begin
                     cmd.load      = 1'b1;
                     cmd.bind_mode = (req_type == sst_pkg::REQ_BIND);
                     bind_in       = (req_type == sst_pkg::REQ_BIND);
                     key_in        = req_key[KEY_W-1:0];
                     value_in      = req_bind_value;
                     remain_in     = (count_ff > COUNT_W'(1)) ? count_ff - COUNT_W'(1)
                                                              : '0;
                     state_in      = sst_pkg::ST_SCAN;
                  end
                  sst_pkg::REQ_PUSH: begin
                     strobe_in = 1'b1;
                     fval_in   = '0;
                     if (level_ff >= LEVEL_W'(MAX_LEVEL)) begin
                        status_in = sst_pkg::STATUS_LEVEL;
                     end else begin
                        status_in = sst_pkg::STATUS_OK;
                        level_in  = level_ff + LEVEL_W'(1);
                     end
                  end
                  sst_pkg::REQ_POP: begin
                     if (level_ff == '0) begin
                        strobe_in = 1'b1;
                        status_in = sst_pkg::STATUS_LEVEL;
                        fval_in   = '0;
                     end else begin
                        state_in = sst_pkg::ST_POP;
                     end
                  end
                  default: begin
                     state_in = sst_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         sst_pkg::ST_SCAN: begin
            if (remain_ff != '0) begin
               cmd.step  = 1'b1;
               remain_in = remain_ff - COUNT_W'(1);
            end else begin
               strobe_in = 1'b1;
               fval_in   = '0;
               state_in  = sst_pkg::ST_IDLE;
               if (bind_ff) begin
                  if (head_found) begin
                     status_in = sst_pkg::STATUS_DUP;
                  end else if (count_ff == COUNT_W'(TABLE_DEPTH)) begin
                     status_in = sst_pkg::STATUS_FULL;
                  end else begin
                     status_in    = sst_pkg::STATUS_OK;
                     cmd.shift_in = 1'b1;
                     count_in     = count_ff + COUNT_W'(1);
                  end
               end else if (head_found) begin
                  status_in = sst_pkg::STATUS_OK;
                  fval_in   = head_pval;
               end else begin
                  status_in = sst_pkg::STATUS_MISSING;
               end
            end
         end
         sst_pkg::ST_POP: begin
            // drop the newest entry while it belongs to the closing scope
            if ((count_ff != '0) && (head_level >= level_ff)) begin
               cmd.shift_out = 1'b1;
               count_in      = count_ff - COUNT_W'(1);
            end else begin
               level_in  = level_ff - LEVEL_W'(1);
               strobe_in = 1'b1;
               status_in = sst_pkg::STATUS_OK;
               fval_in   = '0;
               state_in  = sst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sst_pkg::ST_IDLE;
         count_ff  <= '0;
         level_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         level_ff  <= level_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      bind_ff   <= bind_in;
      key_ff    <= key_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      fval_ff   <= fval_in;
   end

   assign busy            = (state_ff != sst_pkg::ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_value = fval_ff;
   assign count           = count_ff;
   assign cur_level       = level_ff;
   assign new_key         = key_ff;
   assign new_value       = value_ff;

endmodule
